// ----- rtl/core/mie_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants for the modular inverse block
// Operand widths, sequencer states and the result record.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Width of remainders, the modulus and the inverse
  localparam int OPW = 31;
  // Width of the alignment shift count (0..OPW-1)
  localparam int KW  = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ALIGN,
    ST_DIVIDE,
    ST_FIX,
    ST_DONE
  } mie_state_t;

  typedef struct packed {
    logic           last;
    logic [OPW-1:0] inverse;
  } mie_result_t;

endpackage
`default_nettype wire

// ----- rtl/core/modular_inverse_ext_euclid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by extended Euclid
// Inverts one element modulo the configured modulus per request.
//
//   channel   dir  signals                          payload
//   s_axis    in   tvalid tready tdata[31:0] tlast  value, last_in
//   m_axis    out  tvalid tready tdata[31:0] tlast  inverse, last_out
//   cfg       in   cfg_we cfg_wdata[30:0]           modulus
//
// Each Euclid round is an align phase and a divide phase whose length grows
// with the bit-length difference of the two remainders in that round; the shared
// compare/subtract unit does one align or divide step a cycle.
// tready is high only while the sequencer is idle; a finished result moves to
// the output register, and the next request can start while it waits there.
// Reset (synchronous) sets modulus to 2^31-1 and empties the block.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
  parameter int WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_axis_tdata fields from bit 0: value[30:0], zero pad [31]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // m_axis_tdata fields from bit 0: inverse[30:0], zero pad [31]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata
);
  import mie_pkg::*;

  logic [OPW-1:0] modulus;
  logic           core_idle;
  logic           res_valid;
  logic           res_take;
  mie_result_t    res;
  mie_result_t    out_reg;
  logic           start;

  assign s_axis_tready = core_idle;
  assign start         = s_axis_tvalid && s_axis_tready;

  // Hold the modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= {OPW{1'b1}};
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  mie_core #(.WIDTH(WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .start     (start),
    .value     (s_axis_tdata[OPW-1:0]),
    .last_in   (s_axis_tlast),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_reg.inverse};
  assign m_axis_tlast = out_reg.last;

endmodule
`default_nettype wire

// ----- rtl/core/mie_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_alu: shared compare / subtract unit
// One magnitude compare-and-subtract on remainders plus one signed subtract on
// Bezout coefficients, reused by every alignment and division step.
// ----------------------------------------------------------------------------
module mie_alu #(
  parameter int WIDTH = 32
) (
  input  wire logic [mie_pkg::OPW:0]    cmp_a,
  input  wire logic [mie_pkg::OPW:0]    cmp_b,
  input  wire logic signed [WIDTH-1:0]  coef_a,
  input  wire logic signed [WIDTH-1:0]  coef_b,
  output logic                          ge,
  output logic [mie_pkg::OPW:0]         diff,
  output logic signed [WIDTH-1:0]       coef_diff
);
  import mie_pkg::*;

  // Compare and subtract remainders
  assign ge   = (cmp_a >= cmp_b);
  assign diff = cmp_a - cmp_b;

  // Subtract the shifted coefficient
  assign coef_diff = coef_a - coef_b;

endmodule
`default_nettype wire

// ----- rtl/core/mie_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_core: extended Euclid sequencer
// Runs Euclid rounds, each a shift-align phase and a restoring divide phase on
// the shared unit, tracking the coefficient of the input, then folds it into
// 0..modulus-1.
// ----------------------------------------------------------------------------
module mie_core #(
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [mie_pkg::OPW-1:0]  modulus,
  input  wire logic                     start,
  input  wire logic [mie_pkg::OPW-1:0]  value,
  input  wire logic                     last_in,
  output logic                          idle,
  output logic                          res_valid,
  input  wire logic                     res_take,
  output mie_pkg::mie_result_t          res
);
  import mie_pkg::*;

  localparam int MAX_ROUNDS = 2 * WIDTH;
  localparam int RW         = $clog2(MAX_ROUNDS + 1);
  localparam int SW         = WIDTH + 32;

  mie_state_t state, state_next;

  logic [OPW-1:0]          a, a_next, b, b_next, r, r_next, d, d_next;
  logic signed [WIDTH-1:0] sa, sa_next, sb, sb_next, acc, acc_next, sd, sd_next;
  logic [KW-1:0]           k, k_next;
  logic [RW-1:0]           rounds, rounds_next;
  logic                    last, last_next;
  logic [OPW-1:0]          inv, inv_next;

  logic [OPW:0]            cmp_b;
  logic                    alu_ge;
  logic [OPW:0]            alu_diff;
  logic signed [WIDTH-1:0] alu_coef;

  logic [OPW-1:0]          r_new;
  logic signed [WIDTH-1:0] acc_new;
  logic signed [SW-1:0]    sa_ext, fix_sum;

  // Shared unit: align compares r with 2d, divide compares r with d
  assign cmp_b = (state == ST_ALIGN) ? {d, 1'b0} : {1'b0, d};

  mie_alu #(.WIDTH(WIDTH)) u_alu (
    .cmp_a     ({1'b0, r}),
    .cmp_b     (cmp_b),
    .coef_a    (acc),
    .coef_b    (sd),
    .ge        (alu_ge),
    .diff      (alu_diff),
    .coef_diff (alu_coef)
  );

  assign r_new   = alu_ge ? alu_diff[OPW-1:0] : r;
  assign acc_new = alu_ge ? alu_coef : acc;

  // Fold a negative coefficient into range
  assign sa_ext  = {{32{sa[WIDTH-1]}}, sa};
  assign fix_sum = sa_ext + signed'({(WIDTH + 1)'(0), modulus});

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res.last    = last;
  assign res.inverse = inv;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rounds <= '0;
    end else begin
      state  <= state_next;
      rounds <= rounds_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a    <= a_next;
    b    <= b_next;
    r    <= r_next;
    d    <= d_next;
    sa   <= sa_next;
    sb   <= sb_next;
    acc  <= acc_next;
    sd   <= sd_next;
    k    <= k_next;
    last <= last_next;
    inv  <= inv_next;
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    a_next      = a;
    b_next      = b;
    r_next      = r;
    d_next      = d;
    sa_next     = sa;
    sb_next     = sb;
    acc_next    = acc;
    sd_next     = sd;
    k_next      = k;
    rounds_next = rounds;
    last_next   = last;
    inv_next    = inv;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          a_next      = value;
          b_next      = modulus;
          sa_next     = WIDTH'(1);
          sb_next     = '0;
          rounds_next = '0;
          last_next   = last_in;
          // Degenerate modulus: skip straight to a zero result
          if (modulus < OPW'(2)) begin
            b_next  = '0;
            sa_next = '0;
          end
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if ((b == '0) || (rounds == RW'(MAX_ROUNDS))) begin
          state_next = ST_FIX;
        end else begin
          r_next     = a;
          d_next     = b;
          acc_next   = sa;
          sd_next    = sb;
          k_next     = '0;
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // Double the divisor while it still fits under the remainder
        if (alu_ge) begin
          d_next  = {d[OPW-2:0], 1'b0};
          sd_next = sd <<< 1;
          k_next  = k + 1'b1;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (k == '0) begin
          a_next      = b;
          b_next      = r_new;
          sa_next     = sb;
          sb_next     = acc_new;
          rounds_next = rounds + 1'b1;
          state_next  = ST_ROUND;
        end else begin
          r_next   = r_new;
          acc_next = acc_new;
          d_next   = {1'b0, d[OPW-1:1]};
          sd_next  = sd >>> 1;
          k_next   = k - 1'b1;
        end
      end
      ST_FIX: begin
        inv_next   = sa[WIDTH-1] ? fix_sum[OPW-1:0] : sa_ext[OPW-1:0];
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_round_limit: assert property (@(posedge clk) disable iff (rst)
    rounds <= RW'(MAX_ROUNDS))
    else $error("round counter past its limit");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> ({1'b0, r} < {d, 1'b0}))
    else $error("partial remainder not below twice the divisor");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) && (k == '0) |=> (state == ST_ROUND))
    else $error("last divide step did not close the round");
`endif

endmodule
`default_nettype wire
